### sv/rectilinear_grid_bilinear_sampler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectilinear grid bilinear sampler
// Shared macros for concurrent assertions, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef RECTILINEAR_GRID_BILINEAR_SAMPLER_DEFINES_SVH
`define RECTILINEAR_GRID_BILINEAR_SAMPLER_DEFINES_SVH

// Assertion with an explicit clock and active-low reset.
`define RGBS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assertion on the block clock and reset.
`define RGBS_ASSERT(lbl, prop, msg) `RGBS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### sv/rgbs_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear sampler package
// Types and constants shared by the sampler, its channels and its checker.
// ----------------------------------------------------------------------------
package rgbs_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Table sizes; the index and count fields are sized for these.
  localparam int unsigned MAX_X_POINTS = 64;
  localparam int unsigned MAX_Y_POINTS = 64;

  // Commands carried by a request.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_X = 2'd0,
    CMD_LOAD_Y = 2'd1,
    CMD_LOAD_Z = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  // Response status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_CLAMPED = 2'd1,
    STAT_RANGE   = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS = 2'd1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENDS0,
    ST_ENDS1,
    ST_EDGE,
    ST_MID,
    ST_CMP,
    ST_HI,
    ST_SPAN,
    ST_DIV,
    ST_ZRD,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } state_e;

  // How the weight of one axis is formed.
  typedef enum logic [1:0] {
    W_ZERO,
    W_ONE,
    W_DIV
  } wmode_e;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [IDX_W-1:0]        x_index;
    logic [IDX_W-1:0]        y_index;
    logic signed [VAL_W-1:0] load_value;
    logic signed [VAL_W-1:0] query_x;
    logic signed [VAL_W-1:0] query_y;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] elevation;
    logic [STAT_W-1:0]       status;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;
  } cfg_t;

endpackage

### sv/rgbs_if.sv
// ----------------------------------------------------------------------------
// Sampler channels
// Valid/ready channels for requests, responses and configuration writes.
// ----------------------------------------------------------------------------

// Request channel.
interface rgbs_req_if;
  logic           valid;
  logic           ready;
  rgbs_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// Response channel.
interface rgbs_rsp_if;
  logic           valid;
  logic           ready;
  rgbs_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// Configuration write channel.
interface rgbs_cfg_if;
  logic           valid;
  logic           ready;
  rgbs_pkg::cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/rectilinear_grid_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// Rectilinear grid bilinear sampler
// Holds x, y and elevation tables in memories and answers bilinear queries.
// ----------------------------------------------------------------------------
// Usage: req_i carries one request per valid/ready handshake. Load commands
// write one x coordinate, y coordinate or elevation word; a query returns the
// interpolated elevation. Every request gives exactly one response on rsp_o.
// cfg_i sets the x and y point counts and is always ready; write it only
// while no request is in flight.
// Timing: a load goes straight to the response state. A query reads the table
// ends, runs a binary search on each axis (depth at most ceil(log2(count-1))),
// reads the upper bracket entries, divides for the weights and reads the four
// corners before the blend. Each search step waits on a registered memory
// read, and the weight divider retires one quotient bit per cycle. One request
// is in flight at a time, and the next one is taken the cycle after the
// response is registered.
// Reset: counts return to 2 and the tables hold nothing valid until loaded.
// Stall: a finished response waits in the output register; the next request
// is accepted meanwhile and its own response holds until rsp_o is taken.
// ----------------------------------------------------------------------------
module rectilinear_grid_bilinear_sampler #(
  parameter int unsigned WEIGHT_FRACTION_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rgbs_req_if.sink   req_i,
  rgbs_rsp_if.source rsp_o,
  rgbs_cfg_if.sink   cfg_i
);

  localparam int unsigned MAX_X_POINTS = rgbs_pkg::MAX_X_POINTS;
  localparam int unsigned MAX_Y_POINTS = rgbs_pkg::MAX_Y_POINTS;
  localparam int unsigned VW  = rgbs_pkg::VAL_W;
  localparam int unsigned CW  = rgbs_pkg::CNT_W;
  localparam int unsigned WF  = WEIGHT_FRACTION_BITS;
  localparam int unsigned XAW = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
  localparam int unsigned YAW = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
  localparam int unsigned ZAW = $clog2(MAX_X_POINTS * MAX_Y_POINTS);
  localparam int unsigned DW  = VW + 1;
  localparam int unsigned PW  = DW + WF + 2;
  localparam int unsigned DCW = $clog2(WF + 1);
  localparam logic [ZAW-1:0] ZROW = ZAW'(MAX_Y_POINTS);
  localparam logic [WF:0]    W_ONE_VAL = (WF+1)'(1) << WF;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (WF - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CW-1:0] n_q [2];

  assign cfg_i.ready = 1'b1;

  function automatic logic [CW-1:0] clamp_count(logic [CW-1:0] v, int unsigned maxv);
    logic [CW-1:0] r;
    if (v < CW'(2)) r = CW'(2);
    else if (32'(v) > maxv) r = CW'(maxv);
    else r = v;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q[0] <= CW'(2);
      n_q[1] <= CW'(2);
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        rgbs_pkg::CFG_X_POINTS: n_q[0] <= clamp_count(cfg_i.payload.data, MAX_X_POINTS);
        rgbs_pkg::CFG_Y_POINTS: n_q[1] <= clamp_count(cfg_i.payload.data, MAX_Y_POINTS);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // State and datapath registers
  // ---------------------------------------------------------------------
  rgbs_pkg::state_e state_q, state_d;
  logic req_acc;
  logic [rgbs_pkg::CMD_W-1:0] cmd;
  logic [rgbs_pkg::IDX_W-1:0] xi, yi;
  logic x_in_range, y_in_range;

  logic signed [VW-1:0] q_q   [2];
  logic signed [VW-1:0] c0_q  [2];
  logic signed [VW-1:0] clo_q [2];
  logic [CW-1:0]        lo_q  [2];
  logic [CW-1:0]        hi_q  [2];
  rgbs_pkg::wmode_e     wm_q  [2];
  logic [DW:0]          rem_q [2];
  logic [DW-1:0]        den_q [2];
  logic [WF-1:0]        quo_q [2];
  logic signed [VW-1:0] z_q   [4];
  logic [DCW-1:0]       dcnt_q;
  logic [2:0]           zk_q;
  logic [1:0]           mstep_q;
  logic signed [PW-1:0] prod_q;
  logic signed [VW-1:0] lower_q, upper_q, res_q;
  logic [rgbs_pkg::STAT_W-1:0] stat_q;
  logic outside_q;

  logic rsp_valid_q;
  rgbs_pkg::rsp_t rsp_q;

  // Memories and read data
  logic signed [VW-1:0] x_mem [MAX_X_POINTS];
  logic signed [VW-1:0] y_mem [MAX_Y_POINTS];
  logic signed [VW-1:0] z_mem [MAX_X_POINTS * MAX_Y_POINTS];
  logic signed [VW-1:0] rd_q [2];
  logic signed [VW-1:0] zrd_q;
  logic [CW-1:0]  raddr [2];
  logic [ZAW-1:0] zraddr;

  assign req_i.ready = (state_q == rgbs_pkg::ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cmd         = req_i.payload.command;
  assign xi          = req_i.payload.x_index;
  assign yi          = req_i.payload.y_index;
  assign x_in_range  = {1'b0, xi} < n_q[0];
  assign y_in_range  = {1'b0, yi} < n_q[1];

  // Table writes happen at acceptance of a load; reads are registered.
  always_ff @(posedge clk_i) begin
    if (req_acc && cmd == rgbs_pkg::CMD_LOAD_X && x_in_range) begin
      x_mem[XAW'(xi)] <= req_i.payload.load_value;
    end
    rd_q[0] <= x_mem[XAW'(raddr[0])];
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && cmd == rgbs_pkg::CMD_LOAD_Y && y_in_range) begin
      y_mem[YAW'(yi)] <= req_i.payload.load_value;
    end
    rd_q[1] <= y_mem[YAW'(raddr[1])];
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && cmd == rgbs_pkg::CMD_LOAD_Z && x_in_range && y_in_range) begin
      z_mem[ZAW'(xi) * ZROW + ZAW'(yi)] <= req_i.payload.load_value;
    end
    zrd_q <= z_mem[zraddr];
  end

  // ---------------------------------------------------------------------
  // Per-axis combinational helpers
  // ---------------------------------------------------------------------
  logic [CW-1:0]        mid [2];
  logic                 active [2];
  logic                 any_active;
  logic signed [VW-1:0] qcl [2];
  logic                 out_ax [2];
  logic signed [DW-1:0] num [2];
  logic signed [DW-1:0] den [2];
  logic [DW:0]          rem2 [2];
  logic [WF:0]          wt [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      active[a] = (hi_q[a] - lo_q[a]) > CW'(1);
      mid[a]    = lo_q[a] + ((hi_q[a] - lo_q[a]) >> 1);
      // Clamp against the first entry, then the last (read data in ST_EDGE).
      qcl[a]    = (q_q[a] < c0_q[a]) ? c0_q[a] : q_q[a];
      out_ax[a] = (q_q[a] < c0_q[a]);
      if (qcl[a] > rd_q[a]) begin
        qcl[a]    = rd_q[a];
        out_ax[a] = 1'b1;
      end
      num[a]  = DW'(q_q[a]) - DW'(clo_q[a]);
      den[a]  = DW'(rd_q[a]) - DW'(clo_q[a]);
      rem2[a] = {rem_q[a][DW-1:0], 1'b0};
      case (wm_q[a])
        rgbs_pkg::W_ONE: wt[a] = W_ONE_VAL;
        rgbs_pkg::W_DIV: wt[a] = {1'b0, quo_q[a]};
        default:         wt[a] = '0;
      endcase
    end
    any_active = active[0] || active[1];
  end

  // Elevation corner address for the read counter.
  logic [CW-1:0] zx, zy;
  always_comb begin
    zx = zk_q[0] ? lo_q[0] + CW'(1) : lo_q[0];
    zy = zk_q[1] ? lo_q[1] + CW'(1) : lo_q[1];
    zraddr = ZAW'(zx) * ZROW + ZAW'(zy);
  end

  // Shared blend multiplier operands.
  logic [WF:0]          m_w;
  logic signed [VW-1:0] m_a, m_b;
  logic signed [PW-1:0] m_sum;
  logic signed [VW-1:0] blend_res;
  always_comb begin
    case (mstep_q)
      2'd0: begin
        m_w = wt[0]; m_a = z_q[0]; m_b = z_q[1];
      end
      2'd1: begin
        m_w = wt[0]; m_a = z_q[2]; m_b = z_q[3];
      end
      default: begin
        m_w = wt[1]; m_a = lower_q; m_b = upper_q;
      end
    endcase
    m_sum     = prod_q + HALF;
    blend_res = m_a + VW'(m_sum >>> WF);
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state and memory read addresses
  // ---------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    raddr[0] = '0;
    raddr[1] = '0;
    case (state_q)
      rgbs_pkg::ST_IDLE: begin
        if (req_acc) begin
          state_d = (cmd == rgbs_pkg::CMD_QUERY) ? rgbs_pkg::ST_ENDS0 : rgbs_pkg::ST_FIN;
        end
      end
      rgbs_pkg::ST_ENDS0: state_d = rgbs_pkg::ST_ENDS1;
      rgbs_pkg::ST_ENDS1: begin
        raddr[0] = n_q[0] - CW'(1);
        raddr[1] = n_q[1] - CW'(1);
        state_d  = rgbs_pkg::ST_EDGE;
      end
      rgbs_pkg::ST_EDGE: state_d = rgbs_pkg::ST_MID;
      rgbs_pkg::ST_MID: begin
        raddr[0] = active[0] ? mid[0] : lo_q[0];
        raddr[1] = active[1] ? mid[1] : lo_q[1];
        state_d  = any_active ? rgbs_pkg::ST_CMP : rgbs_pkg::ST_HI;
      end
      rgbs_pkg::ST_CMP: state_d = rgbs_pkg::ST_MID;
      rgbs_pkg::ST_HI: begin
        raddr[0] = lo_q[0] + CW'(1);
        raddr[1] = lo_q[1] + CW'(1);
        state_d  = rgbs_pkg::ST_SPAN;
      end
      rgbs_pkg::ST_SPAN: state_d = rgbs_pkg::ST_DIV;
      rgbs_pkg::ST_DIV: begin
        if (dcnt_q == '0) state_d = rgbs_pkg::ST_ZRD;
      end
      rgbs_pkg::ST_ZRD: begin
        if (zk_q == 3'd4) state_d = rgbs_pkg::ST_MUL;
      end
      rgbs_pkg::ST_MUL: state_d = rgbs_pkg::ST_ADD;
      rgbs_pkg::ST_ADD: begin
        state_d = (mstep_q == 2'd2) ? rgbs_pkg::ST_FIN : rgbs_pkg::ST_MUL;
      end
      rgbs_pkg::ST_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) state_d = rgbs_pkg::ST_IDLE;
      end
      default: state_d = rgbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rgbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath updates per state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      rgbs_pkg::ST_IDLE: begin
        q_q[0] <= req_i.payload.query_x;
        q_q[1] <= req_i.payload.query_y;
        res_q  <= '0;
        if (cmd == rgbs_pkg::CMD_LOAD_X) begin
          stat_q <= x_in_range ? rgbs_pkg::STAT_OK : rgbs_pkg::STAT_RANGE;
        end else if (cmd == rgbs_pkg::CMD_LOAD_Y) begin
          stat_q <= y_in_range ? rgbs_pkg::STAT_OK : rgbs_pkg::STAT_RANGE;
        end else if (cmd == rgbs_pkg::CMD_LOAD_Z) begin
          stat_q <= (x_in_range && y_in_range) ? rgbs_pkg::STAT_OK : rgbs_pkg::STAT_RANGE;
        end else begin
          stat_q <= rgbs_pkg::STAT_OK;
        end
      end
      rgbs_pkg::ST_ENDS1: begin
        c0_q[0] <= rd_q[0];
        c0_q[1] <= rd_q[1];
      end
      rgbs_pkg::ST_EDGE: begin
        // Clamp each axis and decide whether it sits at an end.
        for (int a = 0; a < 2; a++) begin
          q_q[a] <= qcl[a];
          if (qcl[a] <= c0_q[a]) begin
            lo_q[a] <= '0;
            hi_q[a] <= CW'(1);
            wm_q[a] <= rgbs_pkg::W_ZERO;
          end else if (qcl[a] >= rd_q[a]) begin
            lo_q[a] <= n_q[a] - CW'(2);
            hi_q[a] <= n_q[a] - CW'(1);
            wm_q[a] <= rgbs_pkg::W_ONE;
          end else begin
            lo_q[a] <= '0;
            hi_q[a] <= n_q[a] - CW'(1);
            wm_q[a] <= rgbs_pkg::W_DIV;
          end
        end
        outside_q <= out_ax[0] || out_ax[1];
      end
      rgbs_pkg::ST_CMP: begin
        // One binary search step on each axis still searching.
        for (int a = 0; a < 2; a++) begin
          if (active[a]) begin
            if (rd_q[a] <= q_q[a]) lo_q[a] <= mid[a];
            else hi_q[a] <= mid[a];
          end
        end
      end
      rgbs_pkg::ST_HI: begin
        clo_q[0] <= rd_q[0];
        clo_q[1] <= rd_q[1];
      end
      rgbs_pkg::ST_SPAN: begin
        // Resolve the weight cases that need no division.
        for (int a = 0; a < 2; a++) begin
          rem_q[a] <= {1'b0, num[a]};
          den_q[a] <= den[a];
          if (wm_q[a] == rgbs_pkg::W_DIV) begin
            if (den[a] <= 0 || num[a] <= 0) wm_q[a] <= rgbs_pkg::W_ZERO;
            else if (num[a] >= den[a]) wm_q[a] <= rgbs_pkg::W_ONE;
          end
        end
        dcnt_q <= DCW'(WF - 1);
      end
      rgbs_pkg::ST_DIV: begin
        // Restoring division, one quotient bit per cycle on both axes.
        for (int a = 0; a < 2; a++) begin
          if (rem2[a] >= {1'b0, den_q[a]}) begin
            rem_q[a] <= rem2[a] - {1'b0, den_q[a]};
            quo_q[a] <= {quo_q[a][WF-2:0], 1'b1};
          end else begin
            rem_q[a] <= rem2[a];
            quo_q[a] <= {quo_q[a][WF-2:0], 1'b0};
          end
        end
        dcnt_q <= dcnt_q - DCW'(1);
        zk_q   <= '0;
      end
      rgbs_pkg::ST_ZRD: begin
        // Issue corner k, capture corner k-1.
        if (zk_q != 3'd0) z_q[2'(zk_q - 3'd1)] <= zrd_q;
        zk_q    <= zk_q + 3'd1;
        mstep_q <= '0;
      end
      rgbs_pkg::ST_MUL: begin
        prod_q <= $signed({1'b0, m_w}) * (DW'(m_b) - DW'(m_a));
      end
      rgbs_pkg::ST_ADD: begin
        case (mstep_q)
          2'd0:    lower_q <= blend_res;
          2'd1:    upper_q <= blend_res;
          default: begin
            res_q  <= blend_res;
            stat_q <= outside_q ? rgbs_pkg::STAT_CLAMPED : rgbs_pkg::STAT_OK;
          end
        endcase
        mstep_q <= mstep_q + 2'd1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic rsp_load;
  assign rsp_load = (state_q == rgbs_pkg::ST_FIN) && (!rsp_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q.elevation <= res_q;
      rsp_q.status    <= stat_q;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

### sv/rgbs_checker.sv
// ----------------------------------------------------------------------------
// Sampler port checker
// Port-level assertions on the sampler, attached by bind.
// ----------------------------------------------------------------------------
`include "rectilinear_grid_bilinear_sampler_defines.svh"

module rgbs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [rgbs_pkg::VAL_W-1:0]   rsp_elevation_i,
  input logic [rgbs_pkg::STAT_W-1:0]  rsp_status_i
);

  // A stalled response holds its contents.
  `RGBS_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_elevation_i) && $stable(rsp_status_i), "stalled response changed")

  // Only one request is in flight: ready drops after each acceptance.
  `RGBS_ASSERT(a_one_inflight, req_valid_i && req_ready_i |=> !req_ready_i, "request accepted while busy")

  // Status codes are ok, clamped or out of range.
  `RGBS_ASSERT(a_status_code, rsp_valid_i |-> (rsp_status_i == rgbs_pkg::STAT_OK || rsp_status_i == rgbs_pkg::STAT_CLAMPED || rsp_status_i == rgbs_pkg::STAT_RANGE), "bad status code")

  // A rejected load answers with a zero elevation.
  `RGBS_ASSERT(a_range_zero, rsp_valid_i && rsp_status_i == rgbs_pkg::STAT_RANGE |-> rsp_elevation_i == '0, "rejected load with nonzero value")

endmodule

bind rectilinear_grid_bilinear_sampler rgbs_checker u_rgbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_elevation_i (rsp_o.payload.elevation),
  .rsp_status_i    (rsp_o.payload.status)
);
